@@ rtl/rpmc_pkg.sv @@
// Package for the ramped position move controller: widths, codes, item/state types
// and the reciprocal constant for the per-tick velocity step.
// No dependencies.
`default_nettype none

package rpmc_pkg;

   localparam int DATA_W     = 32;
   localparam int SPEED_W    = 21;
   localparam int VEL_W      = SPEED_W + 1;
   localparam int ADDR_W     = 3;
   localparam int ERR_W      = DATA_W + 1;

   // ticks per second of the position loop
   localparam int CONTROL_RATE = 20;

   // goal_speed / CONTROL_RATE as a multiply by a rounded-up reciprocal; exact for
   // goal_speed < 2**SPEED_W and CONTROL_RATE <= 1000
   localparam int STEP_SHIFT  = 31;
   localparam int STEP_MULT_W = STEP_SHIFT + 1;
   localparam longint unsigned STEP_MULT =
      ((64'd1 << STEP_SHIFT) + CONTROL_RATE - 1) / CONTROL_RATE;
   localparam int PROD_W = SPEED_W + STEP_MULT_W;

   localparam logic [SPEED_W-1:0] SPEED_LIMIT_RESET      = SPEED_W'(16384);
   localparam logic [SPEED_W-1:0] ARRIVE_TOLERANCE_RESET = SPEED_W'(328);

   localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};

   typedef enum logic [1:0] {
      OP_GOAL   = 2'd0,
      OP_MANUAL = 2'd1,
      OP_TICK   = 2'd2,
      OP_CANCEL = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_MOVING    = 2'd0,
      STATUS_SUCCEEDED = 2'd1,
      STATUS_CANCELLED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      DIR_ZERO = 2'b00,
      DIR_POS  = 2'b01
   } dir_type;

   // selected by paddr[2]
   typedef enum logic {
      REG_SPEED_LIMIT      = 1'b0,
      REG_ARRIVE_TOLERANCE = 1'b1
   } reg_sel_type;

   typedef struct packed {
      op_type              op;
      logic [DATA_W-1:0]   target_position;
      logic [DATA_W-1:0]   move_speed;
      logic [1:0]          manual_direction;
      logic [DATA_W-1:0]   measured_position;
      logic                position_valid;
   } item_type;

   typedef struct packed {
      logic                moving;
      logic [VEL_W-1:0]    velocity;
      logic [SPEED_W-1:0]  goal_speed;
      logic [SPEED_W-1:0]  goal_step;
      logic [DATA_W-1:0]   goal_position;
   } ctrl_state_type;

   typedef struct packed {
      logic                valid;
      logic [DATA_W-1:0]   velocity_command;
      status_type          move_status;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/ramped_position_move_controller.sv @@
// Top level of the ramped point-to-point position controller: input register,
// controller state, result register and the APB register file.
// Depends on rpmc_pkg and rpmc_step.
//
//   channel | direction | handshake                 | payload
//   req     | in        | req_valid / req_stall     | op, positions, speed, direction, fix
//   rsp     | out       | rsp_valid / rsp_stall     | velocity_command, move_status
//   csr     | in/out    | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// One transaction per cycle unless rsp_stall holds the output; a request goes through the
// input register, then the single-pass update into the result register that offers it.
// The only loop is the state update, closed combinationally by rpmc_step.
// Reset is synchronous: it clears the move state and restores the register defaults.
// rsp_stall with a result pending holds a full input register and raises req_stall.
`default_nettype none

module ramped_position_move_controller (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_op,
   input  logic signed [rpmc_pkg::DATA_W-1:0] req_target_position,
   input  logic signed [rpmc_pkg::DATA_W-1:0] req_move_speed,
   input  logic signed [1:0]                  req_manual_direction,
   input  logic signed [rpmc_pkg::DATA_W-1:0] req_measured_position,
   input  logic                               req_position_valid,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [rpmc_pkg::DATA_W-1:0] rsp_velocity_command,
   output logic [1:0]                         rsp_move_status,

   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [rpmc_pkg::ADDR_W-1:0]        paddr,
   input  logic [rpmc_pkg::DATA_W-1:0]        pwdata,
   output logic [rpmc_pkg::DATA_W-1:0]        prdata,
   output logic                               pready
);
   import rpmc_pkg::*;

   item_type             req_item;
   item_type             item_ff;
   logic                 item_valid_ff;
   ctrl_state_type       state_ff;
   ctrl_state_type       state_in;
   result_type           result;
   logic                 rsp_valid_ff;
   logic [DATA_W-1:0]    rsp_velocity_ff;
   status_type           rsp_status_ff;
   logic [SPEED_W-1:0]   speed_limit_ff;
   logic [SPEED_W-1:0]   arrive_tolerance_ff;
   logic                 out_blocked;
   logic                 fire;
   logic                 csr_write;
   reg_sel_type          reg_sel;

   assign req_item.op                = op_type'(req_op);
   assign req_item.target_position   = req_target_position;
   assign req_item.move_speed        = req_move_speed;
   assign req_item.manual_direction  = req_manual_direction;
   assign req_item.measured_position = req_measured_position;
   assign req_item.position_valid    = req_position_valid;

   assign out_blocked = rsp_valid_ff && rsp_stall;
   assign req_stall   = item_valid_ff && out_blocked;
   assign fire        = item_valid_ff && !out_blocked;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff <= req_item;
      end
   end

   rpmc_step u_step (
      .item             (item_ff),
      .state            (state_ff),
      .speed_limit      (speed_limit_ff),
      .arrive_tolerance (arrive_tolerance_ff),
      .state_in         (state_in),
      .result           (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && result.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && result.valid) begin
         rsp_velocity_ff <= result.velocity_command;
         rsp_status_ff   <= result.move_status;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_velocity_command = rsp_velocity_ff;
   assign rsp_move_status      = rsp_status_ff;

   // register file; byte lanes below bit 2 are ignored
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign reg_sel   = reg_sel_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_limit_ff      <= SPEED_LIMIT_RESET;
         arrive_tolerance_ff <= ARRIVE_TOLERANCE_RESET;
      end else if (csr_write) begin
         case (reg_sel)
            REG_SPEED_LIMIT:      speed_limit_ff      <= pwdata[SPEED_W-1:0];
            REG_ARRIVE_TOLERANCE: arrive_tolerance_ff <= pwdata[SPEED_W-1:0];
            default:              speed_limit_ff      <= speed_limit_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_SPEED_LIMIT:      prdata = DATA_W'(speed_limit_ff);
         REG_ARRIVE_TOLERANCE: prdata = DATA_W'(arrive_tolerance_ff);
         default:              prdata = '0;
      endcase
   end

`ifndef SYNTHESIS
   // any residual velocity belongs to an open move
   a_velocity_needs_move: assert property (@(posedge clock) disable iff (reset)
      (state_ff.velocity != '0) |-> state_ff.moving)
      else $error("velocity held while no move is open");

   // ramp and error tracking never exceed the goal speed
   a_velocity_bounded: assert property (@(posedge clock) disable iff (reset)
      ($signed(state_ff.velocity) <= $signed({1'b0, state_ff.goal_speed})) &&
      ($signed(state_ff.velocity) >= -$signed({1'b0, state_ff.goal_speed})))
      else $error("stored velocity outside goal speed");

   a_cancel_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_move_status == STATUS_CANCELLED)) |-> (rsp_velocity_command == '0))
      else $error("cancel transaction with nonzero velocity");

   a_moving_result_keeps_move: assert property (@(posedge clock) disable iff (reset)
      (fire && result.valid && (result.move_status == STATUS_MOVING)) |=> state_ff.moving)
      else $error("moving status reported but move closed");
`endif

endmodule

`default_nettype wire

@@ rtl/rpmc_step.sv @@
// Combinational update of the controller for one transaction: next state and result.
// Depends on rpmc_pkg.
`default_nettype none

module rpmc_step (
   input  rpmc_pkg::item_type                item,
   input  rpmc_pkg::ctrl_state_type          state,
   input  logic [rpmc_pkg::SPEED_W-1:0]      speed_limit,
   input  logic [rpmc_pkg::SPEED_W-1:0]      arrive_tolerance,
   output rpmc_pkg::ctrl_state_type          state_in,
   output rpmc_pkg::result_type              result
);
   import rpmc_pkg::*;

   localparam logic [STEP_MULT_W-1:0] STEP_MULT_VEC = STEP_MULT[STEP_MULT_W-1:0];

   // goal start
   logic [DATA_W-1:0]   speed_neg;
   logic [DATA_W-2:0]   speed_mag;
   logic [SPEED_W-1:0]  new_speed;
   logic [PROD_W-1:0]   step_prod;
   logic [SPEED_W-1:0]  new_step;

   // position tick
   logic [ERR_W-1:0]    err;
   logic [ERR_W-1:0]    abs_err;
   logic                far;
   logic                near;
   logic [VEL_W:0]      vel_ext;
   logic [VEL_W:0]      step_ext;
   logic [VEL_W:0]      ramp;
   logic [VEL_W:0]      abs_ramp;
   logic [VEL_W-1:0]    speed_ext;
   logic [VEL_W-1:0]    ramp_vel;
   logic [VEL_W-1:0]    tick_vel;

   // manual command
   logic [DATA_W-1:0]   manual_vel;

   always_comb begin
      speed_neg = DATA_W'(0) - item.move_speed;
      if (!item.move_speed[DATA_W-1]) begin
         speed_mag = item.move_speed[DATA_W-2:0];
      end else if (speed_neg[DATA_W-1]) begin
         speed_mag = '1;   // most negative input saturates
      end else begin
         speed_mag = speed_neg[DATA_W-2:0];
      end
      new_speed = (speed_mag > (DATA_W-1)'(speed_limit)) ? '0 : speed_mag[SPEED_W-1:0];
      step_prod = PROD_W'(new_speed) * PROD_W'(STEP_MULT_VEC);
      new_step  = step_prod[STEP_SHIFT +: SPEED_W];
   end

   always_comb begin
      err = {state.goal_position[DATA_W-1], state.goal_position}
          - {item.measured_position[DATA_W-1], item.measured_position};
      abs_err = err[ERR_W-1] ? (ERR_W'(0) - err) : err;
      far  = abs_err > ERR_W'(state.goal_speed);
      near = abs_err < ERR_W'(arrive_tolerance);

      vel_ext   = {state.velocity[VEL_W-1], state.velocity};
      step_ext  = (VEL_W+1)'(state.goal_step);
      ramp      = err[ERR_W-1] ? (vel_ext - step_ext) : (vel_ext + step_ext);
      abs_ramp  = ramp[VEL_W] ? ((VEL_W+1)'(0) - ramp) : ramp;
      speed_ext = VEL_W'(state.goal_speed);
      if (abs_ramp > (VEL_W+1)'(state.goal_speed)) begin
         ramp_vel = err[ERR_W-1] ? (VEL_W'(0) - speed_ext) : speed_ext;
      end else begin
         ramp_vel = ramp[VEL_W-1:0];
      end

      // |err| <= goal_speed when not far, so the low bits hold it exactly
      if (near) begin
         tick_vel = '0;
      end else if (far) begin
         tick_vel = ramp_vel;
      end else begin
         tick_vel = err[VEL_W-1:0];
      end
   end

   always_comb begin
      case (item.manual_direction)
         DIR_POS:  manual_vel = item.move_speed;
         DIR_ZERO: manual_vel = '0;
         default:  manual_vel = (item.move_speed == DATA_MIN) ? DATA_MAX : speed_neg;
      endcase
   end

   always_comb begin
      state_in                = state;
      result.valid            = 1'b0;
      result.velocity_command = '0;
      result.move_status      = STATUS_MOVING;
      case (item.op)
         OP_GOAL: begin
            state_in.moving        = 1'b1;
            state_in.velocity      = '0;
            state_in.goal_speed    = new_speed;
            state_in.goal_step     = new_step;
            state_in.goal_position = item.target_position;
         end
         OP_MANUAL: begin
            state_in.moving         = 1'b0;
            state_in.velocity       = '0;
            result.valid            = 1'b1;
            result.velocity_command = manual_vel;
            result.move_status      = STATUS_SUCCEEDED;
         end
         OP_TICK: begin
            if (item.position_valid && state.moving) begin
               state_in.velocity       = tick_vel;
               state_in.moving         = !near;
               result.valid            = 1'b1;
               result.velocity_command = {{(DATA_W-VEL_W){tick_vel[VEL_W-1]}}, tick_vel};
               result.move_status      = near ? STATUS_SUCCEEDED : STATUS_MOVING;
            end
         end
         OP_CANCEL: begin
            if (state.moving) begin
               state_in.moving    = 1'b0;
               state_in.velocity  = '0;
               result.valid       = 1'b1;
               result.move_status = STATUS_CANCELLED;
            end
         end
         default: begin
            state_in = state;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// Self-checking bench for the ramped position move controller: directed table, then
// randomized move sequences across register settings, checked by a per-transaction predictor.
// Depends on rpmc_pkg and ramped_position_move_controller.
`timescale 1ns / 100ps

module testbench;
   import rpmc_pkg::*;

   localparam logic [1:0] DIR_NEG     = 2'b11;
   localparam logic [1:0] DIR_NEG_SAT = 2'b10;  // -2 pattern, behaves as -1
   localparam longint    POS_MAX     = 64'sd2147483647;
   localparam longint    POS_MIN     = -64'sd2147483648;

   typedef struct {
      logic [DATA_W-1:0] vel;
      status_type        status;
   } motion_result_type;

   typedef struct {
      item_type          cmd;
      bit                typed;
      bit                has;
      motion_result_type res;
   } plan_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_op = '0;
   logic [DATA_W-1:0] req_target_position = '0;
   logic [DATA_W-1:0] req_move_speed = '0;
   logic [1:0]        req_manual_direction = '0;
   logic [DATA_W-1:0] req_measured_position = '0;
   logic              req_position_valid = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [DATA_W-1:0] rsp_velocity_command;
   logic [1:0]        rsp_move_status;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   // predictor copy of the controller state and registers
   bit     axis_moving;
   longint axis_vel;
   longint axis_goal_speed;
   longint axis_goal_pos;
   longint cfg_speed_limit;
   longint cfg_tolerance;

   motion_result_type pending_results[$];
   motion_result_type want_result;
   plan_row_type      plan[$];
   int                errors;
   int                counted;
   bit                stall_on;

   ramped_position_move_controller u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_op                (req_op),
      .req_target_position   (req_target_position),
      .req_move_speed        (req_move_speed),
      .req_manual_direction  (req_manual_direction),
      .req_measured_position (req_measured_position),
      .req_position_valid    (req_position_valid),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_velocity_command  (rsp_velocity_command),
      .rsp_move_status       (rsp_move_status),
      .psel                  (psel),
      .penable               (penable),
      .pwrite                (pwrite),
      .paddr                 (paddr),
      .pwdata                (pwdata),
      .prdata                (prdata),
      .pready                (pready)
   );

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("ramped_position_move_controller verification failed");
      $finish;
   end

   function automatic longint abs_l(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic longint clamp32(input longint v);
      if (v > POS_MAX) return POS_MAX;
      if (v < POS_MIN) return POS_MIN;
      return v;
   endfunction

   // next velocity command for one transaction; updates the predicted state
   function automatic void forecast(input item_type it, output bit has,
                                    output motion_result_type res);
      longint spd, mag, err, sgn, vel;
      has = 1'b0;
      res.vel = '0;
      res.status = STATUS_MOVING;
      spd = longint'($signed(it.move_speed));
      case (it.op)
         OP_GOAL: begin
            mag = clamp32(abs_l(spd));
            if (mag > cfg_speed_limit) mag = 0;
            axis_goal_speed = mag;
            axis_goal_pos = longint'($signed(it.target_position));
            axis_vel = 0;
            axis_moving = 1'b1;
         end
         OP_MANUAL: begin
            case (it.manual_direction)
               DIR_POS:  sgn = 1;
               DIR_ZERO: sgn = 0;
               default:  sgn = -1;
            endcase
            axis_moving = 1'b0;
            axis_vel = 0;
            has = 1'b1;
            res.vel = DATA_W'(clamp32(sgn * spd));
            res.status = STATUS_SUCCEEDED;
         end
         OP_TICK: begin
            if (it.position_valid && axis_moving) begin
               err = axis_goal_pos - longint'($signed(it.measured_position));
               sgn = (err > 0) ? 1 : ((err < 0) ? -1 : 0);
               vel = axis_vel;
               if (abs_l(err) > axis_goal_speed) begin
                  vel += sgn * (axis_goal_speed / CONTROL_RATE);
                  if (abs_l(vel) > axis_goal_speed) vel = sgn * axis_goal_speed;
               end else begin
                  vel = err;
               end
               if (abs_l(err) < cfg_tolerance) begin
                  vel = 0;
                  res.status = STATUS_SUCCEEDED;
                  axis_moving = 1'b0;
               end
               vel = clamp32(vel);
               axis_vel = vel;
               has = 1'b1;
               res.vel = DATA_W'(vel);
            end
         end
         default: begin
            if (axis_moving) begin
               axis_moving = 1'b0;
               axis_vel = 0;
               has = 1'b1;
               res.status = STATUS_CANCELLED;
            end
         end
      endcase
   endfunction

   function automatic item_type rand_item();
      item_type it;
      it.op = op_type'($urandom_range(0, 3));
      it.target_position = $urandom;
      it.move_speed = $urandom;
      it.manual_direction = 2'($urandom);
      it.measured_position = $urandom;
      it.position_valid = 1'($urandom);
      return it;
   endfunction

   function automatic plan_row_type mk_row(input op_type op, input logic [DATA_W-1:0] tgt,
                                           input logic [DATA_W-1:0] spd, input logic [1:0] dir,
                                           input logic [DATA_W-1:0] meas, input logic pv,
                                           input bit typed, input bit has,
                                           input logic [DATA_W-1:0] vel, input status_type st);
      plan_row_type r;
      r.cmd.op = op;
      r.cmd.target_position = tgt;
      r.cmd.move_speed = spd;
      r.cmd.manual_direction = dir;
      r.cmd.measured_position = meas;
      r.cmd.position_valid = pv;
      r.typed = typed;
      r.has = has;
      r.res.vel = vel;
      r.res.status = st;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      if (errors < 40)
         $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // drive one transaction and hold it until the controller takes it
   task automatic send_cmd(input item_type it, input int gap_pct);
      if ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= it.op;
      req_target_position <= it.target_position;
      req_move_speed <= it.move_speed;
      req_manual_direction <= it.manual_direction;
      req_measured_position <= it.measured_position;
      req_position_valid <= it.position_valid;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic issue(input item_type it, input int gap_pct);
      bit has;
      motion_result_type res;
      send_cmd(it, gap_pct);
      forecast(it, has, res);
      if (has) pending_results.push_back(res);
      counted++;
   endtask

   // stop sending and let the pipeline empty before touching registers
   task automatic quiesce();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_write(input reg_sel_type sel, input logic [DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {sel, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (sel == REG_SPEED_LIMIT) cfg_speed_limit = value[SPEED_W-1:0];
      else cfg_tolerance = value[SPEED_W-1:0];
   endtask

   // goal followed by ticks closing in on the target, sometimes overshooting
   task automatic move_sequence(input int gap_pct);
      item_type it;
      longint mag, tgt, d, dd;
      int n;
      it = rand_item();
      it.op = OP_GOAL;
      if ($urandom_range(0, 2) != 0)
         it.target_position = DATA_W'($urandom_range(0, 1 << 23)) - DATA_W'(1 << 22);
      case ($urandom_range(0, 7))
         0:       mag = $urandom;
         1:       mag = cfg_speed_limit + 1;
         2:       mag = cfg_speed_limit;
         default: mag = $urandom_range(0, 32'(cfg_speed_limit));
      endcase
      it.move_speed = DATA_W'($urandom_range(0, 1) ? -mag : mag);
      tgt = longint'($signed(it.target_position));
      issue(it, gap_pct);
      case ($urandom_range(0, 3))
         0:       d = $urandom_range(0, 32'(2 * cfg_tolerance + 16));
         1:       d = $urandom_range(0, 32'(4 * axis_goal_speed + 64));
         2:       d = $urandom_range(0, 1 << 24);
         default: d = longint'($urandom);
      endcase
      n = $urandom_range(2, 24);
      for (int k = 0; k < n; k++) begin
         it = rand_item();
         it.op = OP_TICK;
         it.position_valid = ($urandom_range(0, 9) != 0);
         case ($urandom_range(0, 19))
            0:       dd = cfg_tolerance;
            1:       dd = cfg_tolerance - 1;
            2:       dd = axis_goal_speed;
            3:       dd = axis_goal_speed + 1;
            default: dd = d;
         endcase
         if ($urandom_range(0, 5) == 0) dd = -dd;
         it.measured_position = DATA_W'(clamp32(tgt - dd));
         issue(it, gap_pct);
         d = d * $urandom_range(20, 95) / 100;
         if (!axis_moving && $urandom_range(0, 1) != 0) break;
         if ($urandom_range(0, 24) == 0) begin
            it = rand_item();
            it.op = $urandom_range(0, 1) ? OP_CANCEL : OP_MANUAL;
            issue(it, gap_pct);
            break;
         end
      end
   endtask

   always begin
      @(posedge clock);
      if (stall_on && $urandom_range(0, 2) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 17)) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending", rsp_velocity_command, '0);
         end else begin
            want_result = pending_results.pop_front();
            if (rsp_velocity_command !== want_result.vel)
               report_mismatch("velocity_command", rsp_velocity_command, want_result.vel);
            if (rsp_move_status !== want_result.status)
               report_mismatch("move_status", DATA_W'(rsp_move_status),
                               DATA_W'(want_result.status));
         end
      end
   end

   initial begin
      bit has;
      motion_result_type res;
      longint lim, tol;
      int gap_pct;
      errors = 0;
      counted = 0;
      stall_on = 1'b1;
      axis_moving = 1'b0;
      axis_vel = 0;
      axis_goal_speed = 0;
      axis_goal_pos = 0;
      cfg_speed_limit = SPEED_LIMIT_RESET;
      cfg_tolerance = ARRIVE_TOLERANCE_RESET;

      // directed table, run with the reset register values
      plan.push_back(mk_row(OP_TICK, 0, 0, DIR_ZERO, 0, 1, 1, 0, 0, STATUS_MOVING));
      plan.push_back(mk_row(OP_CANCEL, 0, 0, DIR_ZERO, 0, 1, 1, 0, 0, STATUS_MOVING));
      plan.push_back(mk_row(OP_MANUAL, 0, DATA_MAX, DIR_POS, 0, 0, 1, 1, DATA_MAX,
                            STATUS_SUCCEEDED));
      plan.push_back(mk_row(OP_MANUAL, 0, DATA_MIN, DIR_NEG, 0, 0, 1, 1, DATA_MAX,
                            STATUS_SUCCEEDED));
      plan.push_back(mk_row(OP_MANUAL, 0, 5, DIR_NEG_SAT, 0, 0, 1, 1, 32'hFFFF_FFFB,
                            STATUS_SUCCEEDED));
      plan.push_back(mk_row(OP_MANUAL, 0, 123, DIR_ZERO, 0, 0, 1, 1, 0, STATUS_SUCCEEDED));
      plan.push_back(mk_row(OP_MANUAL, 0, DATA_MAX, DIR_NEG, 0, 0, 1, 1, 32'h8000_0001,
                            STATUS_SUCCEEDED));
      plan.push_back(mk_row(OP_GOAL, 65536, 32'hFFFF_C000, DIR_ZERO, 0, 0, 1, 0, 0,
                            STATUS_MOVING));
      plan.push_back(mk_row(OP_TICK, 0, 0, DIR_ZERO, 0, 0, 1, 0, 0, STATUS_MOVING));
      plan.push_back(mk_row(OP_TICK, 0, 0, DIR_ZERO, 0, 1, 1, 1, 819, STATUS_MOVING));
      plan.push_back(mk_row(OP_TICK, 0, 0, DIR_ZERO, 60000, 1, 0, 0, 0, STATUS_MOVING));
      // error exactly at the tolerance still counts as moving
      plan.push_back(mk_row(OP_TICK, 0, 0, DIR_ZERO, 65208, 1, 0, 0, 0, STATUS_MOVING));
      plan.push_back(mk_row(OP_TICK, 0, 0, DIR_ZERO, 65209, 1, 1, 1, 0, STATUS_SUCCEEDED));
      plan.push_back(mk_row(OP_TICK, 0, 0, DIR_ZERO, 0, 1, 1, 0, 0, STATUS_MOVING));
      plan.push_back(mk_row(OP_GOAL, DATA_MIN, DATA_MIN, DIR_ZERO, 0, 0, 1, 0, 0,
                            STATUS_MOVING));
      plan.push_back(mk_row(OP_TICK, 0, 0, DIR_ZERO, DATA_MAX, 1, 0, 0, 0, STATUS_MOVING));
      plan.push_back(mk_row(OP_CANCEL, 0, 0, DIR_ZERO, 0, 0, 1, 1, 0, STATUS_CANCELLED));
      plan.push_back(mk_row(OP_GOAL, DATA_MAX, 16385, DIR_ZERO, 0, 0, 1, 0, 0,
                            STATUS_MOVING));
      plan.push_back(mk_row(OP_TICK, 0, 0, DIR_ZERO, DATA_MIN, 1, 0, 0, 0, STATUS_MOVING));
      plan.push_back(mk_row(OP_GOAL, 0, 16384, DIR_ZERO, 0, 0, 1, 0, 0, STATUS_MOVING));
      plan.push_back(mk_row(OP_TICK, 0, 0, DIR_ZERO, 0, 1, 1, 1, 0, STATUS_SUCCEEDED));
      plan.push_back(mk_row(OP_GOAL, 1000, 100, DIR_ZERO, 0, 0, 1, 0, 0, STATUS_MOVING));
      plan.push_back(mk_row(OP_TICK, 0, 0, DIR_ZERO, 0, 1, 0, 0, 0, STATUS_MOVING));
      plan.push_back(mk_row(OP_MANUAL, 0, 32'hFFFF_FFF9, DIR_POS, 0, 0, 1, 1, 32'hFFFF_FFF9,
                            STATUS_SUCCEEDED));
      plan.push_back(mk_row(OP_CANCEL, 0, 0, DIR_ZERO, 0, 0, 1, 0, 0, STATUS_MOVING));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         send_cmd(plan[i].cmd, 20);
         forecast(plan[i].cmd, has, res);
         if (plan[i].typed) begin
            has = plan[i].has;
            res = plan[i].res;
         end
         if (has) pending_results.push_back(res);
      end

      for (int ph = 0; ph < 8; ph++) begin
         quiesce();
         case (ph)
            0: begin lim = 1048576; tol = 0; end
            1: begin lim = 0; tol = 1048576; end
            2: begin lim = 1048576; tol = 1048576; end
            3: begin lim = 0; tol = 0; end
            7: begin lim = SPEED_LIMIT_RESET; tol = ARRIVE_TOLERANCE_RESET; end
            default: begin
               lim = $urandom_range(0, 1048576);
               tol = $urandom_range(0, (ph == 4) ? 1048576 : 2048);
            end
         endcase
         csr_write(REG_SPEED_LIMIT, DATA_W'(lim));
         csr_write(REG_ARRIVE_TOLERANCE, DATA_W'(tol));
         // final phase runs back to back on both sides
         if (ph == 7) begin
            gap_pct = 0;
            stall_on = 1'b0;
         end else begin
            gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
            stall_on = ($urandom_range(0, 2) != 0);
         end
         counted = 0;
         while (counted < 225) begin
            if ($urandom_range(0, 99) < 75) begin
               move_sequence(gap_pct);
            end else begin
               issue(rand_item(), gap_pct);
            end
         end
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("ramped_position_move_controller verification clean");
      end else begin
         $display("ramped_position_move_controller verification failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/rpmc_pkg.sv
rtl/rpmc_step.sv
rtl/ramped_position_move_controller.sv
test/testbench.sv
